### hw/rtl/lobm_pkg.sv
// Shared types and codes of the limit order book matcher.
package lobm_pkg;

  localparam int unsigned ORDER_SLOTS_DEF = 32;
  localparam int unsigned PRICE_W = 16;
  localparam int unsigned QTY_W   = 24;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned STAMP_W = 32;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  localparam logic [1:0] TIF_GTC  = 2'd0;
  localparam logic [1:0] TIF_IOC  = 2'd1;
  localparam logic [1:0] TIF_FOK  = 2'd2;
  localparam logic [1:0] TIF_POST = 2'd3;

  localparam logic [3:0] ST_FILLED    = 4'd0;
  localparam logic [3:0] ST_RESTED    = 4'd1;
  localparam logic [3:0] ST_DROPPED   = 4'd2;
  localparam logic [3:0] ST_REJECTED  = 4'd3;
  localparam logic [3:0] ST_KILLED    = 4'd4;
  localparam logic [3:0] ST_CANCELLED = 4'd5;
  localparam logic [3:0] ST_MODIFIED  = 4'd6;
  localparam logic [3:0] ST_NOT_FOUND = 4'd7;
  localparam logic [3:0] ST_FULL      = 4'd8;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // One resting order as held in the slot memory.
  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   remaining;
    logic [ID_W-1:0]    ident;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic eval;
    logic opp;
    logic mkt;
  } scan_ctl_t;

  typedef struct packed {
    logic best_found;
    logic match_found;
    logic bid_found;
    logic ask_found;
  } scan_flags_t;

endpackage

### hw/rtl/lobm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lobm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lobm_scan.sv
// Slot scan unit: best opposite order, eligible volume, identifier match, book top.
module lobm_scan #(
  parameter int unsigned ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lobm_pkg::scan_ctl_t                 ctl_i,
  input  logic [lobm_pkg::PRICE_W-1:0]        limit_i,
  input  logic [lobm_pkg::ID_W-1:0]           req_id_i,
  input  logic [lobm_pkg::STAMP_W-1:0]        counter_i,
  input  logic                                slot_valid_i,
  input  lobm_pkg::entry_t                    slot_i,
  input  logic [$clog2(ORDER_SLOTS)-1:0]      slot_idx_i,
  output lobm_pkg::scan_flags_t               flags_o,
  output lobm_pkg::entry_t                    best_o,
  output logic [$clog2(ORDER_SLOTS)-1:0]      best_idx_o,
  output logic [lobm_pkg::QTY_W+$clog2(ORDER_SLOTS+1)-1:0] sum_o,
  output lobm_pkg::entry_t                    match_o,
  output logic [$clog2(ORDER_SLOTS)-1:0]      match_idx_o,
  output logic [lobm_pkg::PRICE_W-1:0]        bid_o,
  output logic [lobm_pkg::PRICE_W-1:0]        ask_o
);

  localparam int unsigned IDX_W = $clog2(ORDER_SLOTS);
  localparam int unsigned SUM_W = lobm_pkg::QTY_W + $clog2(ORDER_SLOTS + 1);

  lobm_pkg::scan_flags_t              flags_q, flags_d;
  lobm_pkg::entry_t                   best_q, best_d, match_q, match_d;
  logic [IDX_W-1:0]                   best_idx_q, best_idx_d, match_idx_q, match_idx_d;
  logic [lobm_pkg::STAMP_W-1:0]       best_age_q, best_age_d, age;
  logic [SUM_W-1:0]                   sum_q, sum_d;
  logic [lobm_pkg::PRICE_W-1:0]       bid_q, bid_d, ask_q, ask_d;
  logic                               eligible, take;

  always_comb begin
    age      = counter_i - slot_i.stamp;
    eligible = slot_valid_i && (slot_i.side == ctl_i.opp) &&
               (ctl_i.mkt || (ctl_i.opp ? (slot_i.price <= limit_i)
                                        : (slot_i.price >= limit_i)));
    if (slot_i.price != best_q.price) begin
      take = ctl_i.opp ? (slot_i.price < best_q.price) : (slot_i.price > best_q.price);
    end else begin
      take = age > best_age_q;
    end

    flags_d     = flags_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    best_age_d  = best_age_q;
    sum_d       = sum_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    bid_d       = bid_q;
    ask_d       = ask_q;

    if (ctl_i.clr) begin
      flags_d = '0;
      sum_d   = '0;
    end else if (ctl_i.eval) begin
      if (eligible) begin
        sum_d = sum_q + SUM_W'(slot_i.remaining);
        if (!flags_q.best_found || take) begin
          flags_d.best_found = 1'b1;
          best_d     = slot_i;
          best_idx_d = slot_idx_i;
          best_age_d = age;
        end
      end
      // keep the lowest slot that holds the identifier
      if (slot_valid_i && !flags_q.match_found && slot_i.ident == req_id_i) begin
        flags_d.match_found = 1'b1;
        match_d     = slot_i;
        match_idx_d = slot_idx_i;
      end
      if (slot_valid_i && !slot_i.side) begin
        if (!flags_q.bid_found || slot_i.price > bid_q) begin
          bid_d = slot_i.price;
        end
        flags_d.bid_found = 1'b1;
      end
      if (slot_valid_i && slot_i.side) begin
        if (!flags_q.ask_found || slot_i.price < ask_q) begin
          ask_d = slot_i.price;
        end
        flags_d.ask_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    best_age_q  <= best_age_d;
    sum_q       <= sum_d;
    match_q     <= match_d;
    match_idx_q <= match_idx_d;
    bid_q       <= bid_d;
    ask_q       <= ask_d;
  end

  assign flags_o     = flags_q;
  assign best_o      = best_q;
  assign best_idx_o  = best_idx_q;
  assign sum_o       = sum_q;
  assign match_o     = match_q;
  assign match_idx_o = match_idx_q;
  assign bid_o       = bid_q;
  assign ask_o       = ask_q;

endmodule

### hw/rtl/limit_order_book_matcher.sv
// Price-time priority limit order book matcher, top level.
// A pass over the book reads all ORDER_SLOTS slots in S_SCAN and then drains in S_DRAIN.
// A cancel, a modify or an add without fills takes two passes, with a decide state between
// them and a status state after them; each fill adds a decide, a trade and a pass.
// One request is in flight at a time, so the next is taken only once the status word has
// been issued and the matcher is idle again. Reset clears valid bits and the stamp counter.
module limit_order_book_matcher #(
  parameter int unsigned ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [lobm_pkg::ID_W-1:0]     order_id_i,
  input  logic                          side_i,
  input  logic                          order_type_i,
  input  logic [1:0]                    time_in_force_i,
  input  logic [lobm_pkg::PRICE_W-1:0]  price_i,
  input  logic [lobm_pkg::QTY_W-1:0]    quantity_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic                          last_o,
  output logic [3:0]                    status_o,
  output logic [lobm_pkg::ID_W-1:0]     buy_id_o,
  output logic [lobm_pkg::ID_W-1:0]     sell_id_o,
  output logic [lobm_pkg::PRICE_W-1:0]  trade_price_o,
  output logic [lobm_pkg::QTY_W-1:0]    fill_quantity_o,
  output logic [lobm_pkg::PRICE_W-1:0]  top_bid_o,
  output logic [lobm_pkg::PRICE_W-1:0]  top_ask_o,
  output logic                          bid_present_o,
  output logic                          ask_present_o
);

  localparam int unsigned IDX_W = $clog2(ORDER_SLOTS);
  localparam int unsigned CNT_W = $clog2(ORDER_SLOTS + 1);
  localparam int unsigned SUM_W = lobm_pkg::QTY_W + CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_TRADE,
    S_STAT
  } state_e;

  state_e state_q, state_d;

  // request registers
  logic [1:0]                   op_q, op_d;
  logic [lobm_pkg::ID_W-1:0]    id_q, id_d;
  logic                         side_q, side_d, mkt_q, mkt_d;
  logic [1:0]                   tif_q, tif_d;
  logic [lobm_pkg::PRICE_W-1:0] price_q, price_d;
  logic [lobm_pkg::QTY_W-1:0]   qty_q, qty_d, rem_q, rem_d;
  logic [lobm_pkg::STAMP_W-1:0] stamp_q, stamp_d, counter_q, counter_d;
  logic [3:0]                   stat_q, stat_d;
  logic [CNT_W-1:0]             fills_q, fills_d;
  logic                         first_q, first_d, final_q, final_d;

  // scan sequencing
  logic [IDX_W-1:0]             idx_q, idx_d, ev_idx_q;
  logic                         ev_q;
  logic [ORDER_SLOTS-1:0]       valid_q, valid_d;

  // result register
  logic                         out_valid_q, out_valid_d;
  logic                         kind_q, kind_d;
  logic [3:0]                   status_q, status_d;
  logic [lobm_pkg::ID_W-1:0]    buy_q, buy_d, sell_q, sell_d;
  logic [lobm_pkg::PRICE_W-1:0] tprice_q, tprice_d, bb_q, bb_d, ba_q, ba_d;
  logic [lobm_pkg::QTY_W-1:0]   fill_q, fill_d;
  logic                         hb_q, hb_d, ha_q, ha_d;

  // memory port
  logic                         ram_we, ram_re;
  logic [IDX_W-1:0]             ram_waddr;
  lobm_pkg::entry_t             ram_wdata, ram_rdata;

  // scan unit
  lobm_pkg::scan_ctl_t          scan_ctl;
  lobm_pkg::scan_flags_t        flags;
  lobm_pkg::entry_t             best, match;
  logic [IDX_W-1:0]             best_idx, match_idx;
  logic [SUM_W-1:0]             sum;
  logic [lobm_pkg::PRICE_W-1:0] bid, ask;

  logic                         out_free, free_any;
  logic [IDX_W-1:0]             free_idx;
  logic [lobm_pkg::QTY_W-1:0]   fill;

  lobm_ram #(
    .WIDTH($bits(lobm_pkg::entry_t)),
    .DEPTH(ORDER_SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign scan_ctl.clr  = (state_q == S_SCAN) && (idx_q == '0);
  assign scan_ctl.eval = ev_q;
  assign scan_ctl.opp  = ~side_q;
  assign scan_ctl.mkt  = mkt_q;

  lobm_scan #(
    .ORDER_SLOTS(ORDER_SLOTS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .limit_i     (price_q),
    .req_id_i    (id_q),
    .counter_i   (counter_q),
    .slot_valid_i(valid_q[ev_idx_q]),
    .slot_i      (ram_rdata),
    .slot_idx_i  (ev_idx_q),
    .flags_o     (flags),
    .best_o      (best),
    .best_idx_o  (best_idx),
    .sum_o       (sum),
    .match_o     (match),
    .match_idx_o (match_idx),
    .bid_o       (bid),
    .ask_o       (ask)
  );

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign fill     = (rem_q < best.remaining) ? rem_q : best.remaining;
  assign ram_re   = (state_q == S_SCAN);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    id_d        = id_q;
    side_d      = side_q;
    mkt_d       = mkt_q;
    tif_d       = tif_q;
    price_d     = price_q;
    qty_d       = qty_q;
    rem_d       = rem_q;
    stamp_d     = stamp_q;
    counter_d   = counter_q;
    stat_d      = stat_q;
    fills_d     = fills_q;
    first_d     = first_q;
    final_d     = final_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    status_d    = status_q;
    buy_d       = buy_q;
    sell_d      = sell_q;
    tprice_d    = tprice_q;
    fill_d      = fill_q;
    bb_d        = bb_q;
    ba_d        = ba_q;
    hb_d        = hb_q;
    ha_d        = ha_q;
    ram_we      = 1'b0;
    ram_waddr   = best_idx;
    ram_wdata   = best;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          id_d    = order_id_i;
          side_d  = side_i;
          mkt_d   = order_type_i;
          tif_d   = time_in_force_i;
          price_d = price_i;
          qty_d   = quantity_i;
          rem_d   = (opcode_i == lobm_pkg::OP_ADD) ? quantity_i : '0;
          stamp_d = counter_q;
          if (opcode_i == lobm_pkg::OP_ADD) begin
            counter_d = counter_q + 1'b1;
          end
          fills_d = '0;
          first_d = 1'b1;
          final_d = 1'b0;
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one slot read a cycle
        idx_d = idx_q + 1'b1;
        if (idx_q == IDX_W'(ORDER_SLOTS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = final_q ? S_STAT : S_DECIDE;
      end
      S_DECIDE: begin
        idx_d   = '0;
        final_d = 1'b1;
        state_d = S_SCAN;
        case (op_q)
          lobm_pkg::OP_ADD: begin
            if (first_q && tif_q == lobm_pkg::TIF_POST && flags.best_found) begin
              stat_d = lobm_pkg::ST_REJECTED;
            end else if (first_q && tif_q == lobm_pkg::TIF_FOK &&
                         sum < SUM_W'(qty_q)) begin
              stat_d = lobm_pkg::ST_KILLED;
            end else if (rem_q != '0 && fills_q != CNT_W'(ORDER_SLOTS) &&
                         flags.best_found) begin
              final_d = 1'b0;
              state_d = S_TRADE;
            end else if (rem_q == '0) begin
              stat_d = lobm_pkg::ST_FILLED;
            end else if (!mkt_q && (tif_q == lobm_pkg::TIF_GTC ||
                                    tif_q == lobm_pkg::TIF_POST)) begin
              if (free_any) begin
                ram_we              = 1'b1;
                ram_waddr           = free_idx;
                ram_wdata.side      = side_q;
                ram_wdata.price     = price_q;
                ram_wdata.remaining = rem_q;
                ram_wdata.ident     = id_q;
                ram_wdata.stamp     = stamp_q;
                valid_d[free_idx]   = 1'b1;
                stat_d              = lobm_pkg::ST_RESTED;
              end else begin
                stat_d = lobm_pkg::ST_FULL;
              end
            end else begin
              stat_d = lobm_pkg::ST_DROPPED;
            end
          end
          lobm_pkg::OP_CANCEL: begin
            if (flags.match_found) begin
              valid_d[match_idx] = 1'b0;
              stat_d             = lobm_pkg::ST_CANCELLED;
            end else begin
              stat_d = lobm_pkg::ST_NOT_FOUND;
            end
          end
          lobm_pkg::OP_MODIFY: begin
            if (flags.match_found) begin
              stat_d = lobm_pkg::ST_MODIFIED;
              if (qty_q == '0) begin
                valid_d[match_idx] = 1'b0;
              end else begin
                // keep stored side and identifier, take a fresh stamp
                ram_we              = 1'b1;
                ram_waddr           = match_idx;
                ram_wdata           = match;
                ram_wdata.price     = price_q;
                ram_wdata.remaining = qty_q;
                ram_wdata.stamp     = counter_q;
                counter_d           = counter_q + 1'b1;
              end
            end else begin
              stat_d = lobm_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            stat_d = lobm_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      S_TRADE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          kind_d              = lobm_pkg::KIND_TRADE;
          status_d            = '0;
          buy_d               = side_q ? best.ident : id_q;
          sell_d              = side_q ? id_q : best.ident;
          tprice_d            = best.price;
          fill_d              = fill;
          bb_d                = '0;
          ba_d                = '0;
          hb_d                = 1'b0;
          ha_d                = 1'b0;
          ram_we              = 1'b1;
          ram_wdata.remaining = best.remaining - fill;
          if (best.remaining == fill) begin
            valid_d[best_idx] = 1'b0;
          end
          rem_d   = rem_q - fill;
          fills_d = fills_q + 1'b1;
          first_d = 1'b0;
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = lobm_pkg::KIND_STATUS;
          status_d    = stat_q;
          buy_d       = '0;
          sell_d      = '0;
          tprice_d    = '0;
          fill_d      = rem_q;
          hb_d        = flags.bid_found;
          ha_d        = flags.ask_found;
          bb_d        = flags.bid_found ? bid : '0;
          ba_d        = flags.ask_found ? ask : '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      counter_q   <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      ev_q        <= 1'b0;
      idx_q       <= '0;
      first_q     <= 1'b0;
      final_q     <= 1'b0;
      fills_q     <= '0;
    end else begin
      state_q     <= state_d;
      counter_q   <= counter_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      ev_q        <= (state_q == S_SCAN);
      idx_q       <= idx_d;
      first_q     <= first_d;
      final_q     <= final_d;
      fills_q     <= fills_d;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    id_q     <= id_d;
    side_q   <= side_d;
    mkt_q    <= mkt_d;
    tif_q    <= tif_d;
    price_q  <= price_d;
    qty_q    <= qty_d;
    rem_q    <= rem_d;
    stamp_q  <= stamp_d;
    stat_q   <= stat_d;
    ev_idx_q <= idx_q;
    kind_q   <= kind_d;
    status_q <= status_d;
    buy_q    <= buy_d;
    sell_q   <= sell_d;
    tprice_q <= tprice_d;
    fill_q   <= fill_d;
    bb_q     <= bb_d;
    ba_q     <= ba_d;
    hb_q     <= hb_d;
    ha_q     <= ha_d;
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign last_o          = kind_q;
  assign status_o        = status_q;
  assign buy_id_o        = buy_q;
  assign sell_id_o       = sell_q;
  assign trade_price_o   = tprice_q;
  assign fill_quantity_o = fill_q;
  assign top_bid_o       = bb_q;
  assign top_ask_o       = ba_q;
  assign bid_present_o   = hb_q;
  assign ask_present_o   = ha_q;

endmodule
